@@ rtl/tpad_pkg.sv @@
package tpad_pkg;

  localparam int MAX_LEVEL = 100;

  localparam int LVL_W   = 7;
  localparam int TIME_W  = 14;
  localparam int SINCE_W = 16;
  localparam int IDX_W   = 3;

  localparam int PROD_W    = LVL_W + TIME_W;
  localparam int DIV_SHIFT = PROD_W + $clog2(MAX_LEVEL);
  localparam int RECIP_W   = DIV_SHIFT - $clog2(MAX_LEVEL) + 1;
  localparam int SCALE_W   = PROD_W + RECIP_W;
  localparam logic [63:0] DIV_RECIP =
    ((64'd1 << DIV_SHIFT) + 64'(MAX_LEVEL) - 64'd1) / 64'(MAX_LEVEL);

  localparam logic [TIME_W-1:0]  RST_DEBOUNCE   = TIME_W'(4000);
  localparam logic [TIME_W-1:0]  RST_MIN_HALF   = TIME_W'(7000);
  localparam logic [TIME_W-1:0]  RST_MAX_HALF   = TIME_W'(12000);
  localparam logic [TIME_W-1:0]  RST_MIN_FIRE   = TIME_W'(300);
  localparam logic [TIME_W-1:0]  RST_END_GUARD  = TIME_W'(700);
  localparam logic [TIME_W-1:0]  RST_GATE_PULSE = TIME_W'(500);
  localparam logic [TIME_W-1:0]  RST_HALF_AVG   = TIME_W'(10000);

  localparam logic [IDX_W-1:0] REG_DIM_LEVEL  = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_DEBOUNCE   = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_MIN_HALF   = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_MAX_HALF   = IDX_W'(3);
  localparam logic [IDX_W-1:0] REG_MIN_FIRE   = IDX_W'(4);
  localparam logic [IDX_W-1:0] REG_END_GUARD  = IDX_W'(5);
  localparam logic [IDX_W-1:0] REG_GATE_PULSE = IDX_W'(6);

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_WAIT  = 2'd1,
    PH_PULSE = 2'd2
  } phase_t;

endpackage

@@ rtl/triac_phase_angle_dimmer_unit.sv @@
// Phase-angle triac dimmer. Each input transfer is one microsecond tick carrying the sampled
// zero-cross pin; each tick yields exactly one result with the gate level, the averaged
// half-cycle length, and flags for an accepted crossing and a started gate pulse. The block
// takes one tick per clock cycle while the output is not stalled; each result passes through the
// registered fire-delay pipeline (window subtraction, level multiply, reciprocal scaling by the
// maximum level, then the phase sequencer). Configuration must be written only while no tick is
// in flight; the block does not enforce this. Writing a level of zero idles the gate at once.
module triac_phase_angle_dimmer_unit
  import tpad_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,   // [0] zero_cross_pin
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [23:0]       m_axis_tdata,   // [0] gate_drive, [14:1] half_cycle_estimate,
                                            // [15] crossing_accepted, [16] gate_fired,
                                            // [18:17] gate_phase
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [TIME_W-1:0] cfg_data
);

  logic [LVL_W-1:0]   dim_level;
  logic [TIME_W-1:0]  debounce_us;
  logic [TIME_W-1:0]  min_half_len;
  logic [TIME_W-1:0]  max_half_len;
  logic [TIME_W-1:0]  min_fire_delay;
  logic [TIME_W-1:0]  guard_len;
  logic [TIME_W-1:0]  pulse_width;

  logic               pin_previous;
  logic [SINCE_W-1:0] since_crossing;
  logic [TIME_W-1:0]  half_cycle_avg;
  phase_t             phase_state;
  logic [TIME_W-1:0]  countdown;

  logic               cfg_write;
  logic [LVL_W-1:0]   level_clamped;
  logic               level_off_write;

  logic               in_xfer;
  logic               pin;
  logic [SINCE_W-1:0] elapsed;
  logic               cross_now;
  logic               in_range;
  logic [TIME_W+3:0]  avg_sum;
  logic [TIME_W-1:0]  half_cycle_avg_next;

  logic               p1_valid;
  logic               p1_accepted;
  logic [TIME_W-1:0]  p1_avg;
  logic               p2_valid;
  logic               p2_accepted;
  logic [TIME_W-1:0]  p2_avg;
  logic               p2_use_min;
  logic [TIME_W-1:0]  p2_latest;
  logic [TIME_W-1:0]  p2_window;
  logic               p3_valid;
  logic               p3_accepted;
  logic [TIME_W-1:0]  p3_avg;
  logic               p3_use_min;
  logic [TIME_W-1:0]  p3_latest;
  logic [PROD_W-1:0]  p3_product;
  logic               p4_valid;
  logic               p4_accepted;
  logic [TIME_W-1:0]  p4_avg;
  logic               p4_use_min;
  logic [TIME_W-1:0]  p4_latest;
  logic [TIME_W-1:0]  p4_quotient;

  logic               ready1;
  logic               ready2;
  logic               ready3;
  logic               ready4;
  logic               out_move;

  logic signed [SINCE_W-1:0] latest;
  logic                      latest_clamp;
  logic [SCALE_W-1:0]        scaled;
  logic [TIME_W-1:0]         fire_delay;

  phase_t             phase_next;
  logic [TIME_W-1:0]  countdown_next;
  logic               fired;
  logic               gate_level;

  logic               out_gate;
  logic [TIME_W-1:0]  out_avg;
  logic               out_accepted;
  logic               out_fired;
  phase_t             out_phase;

  // Configuration port.
  assign cfg_ready       = 1'b1;
  assign cfg_write       = cfg_valid && cfg_ready;
  assign level_clamped   = (32'(cfg_data[LVL_W-1:0]) > 32'(MAX_LEVEL)) ?
                           LVL_W'(MAX_LEVEL) : cfg_data[LVL_W-1:0];
  assign level_off_write = cfg_write && (cfg_index == REG_DIM_LEVEL) &&
                           (level_clamped == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      dim_level      <= '0;
      debounce_us    <= RST_DEBOUNCE;
      min_half_len   <= RST_MIN_HALF;
      max_half_len   <= RST_MAX_HALF;
      min_fire_delay <= RST_MIN_FIRE;
      guard_len      <= RST_END_GUARD;
      pulse_width    <= RST_GATE_PULSE;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_DIM_LEVEL:  dim_level      <= level_clamped;
        REG_DEBOUNCE:   debounce_us    <= cfg_data;
        REG_MIN_HALF:   min_half_len   <= cfg_data;
        REG_MAX_HALF:   max_half_len   <= cfg_data;
        REG_MIN_FIRE:   min_fire_delay <= cfg_data;
        REG_END_GUARD:  guard_len      <= cfg_data;
        REG_GATE_PULSE: pulse_width    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline flow control.
  assign out_move      = p4_valid && (!m_axis_tvalid || m_axis_tready);
  assign ready4        = !p4_valid || out_move;
  assign ready3        = !p3_valid || ready4;
  assign ready2        = !p2_valid || ready3;
  assign ready1        = !p1_valid || ready2;
  assign s_axis_tready = ready1;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // Crossing detection and half-cycle averaging.
  assign pin       = s_axis_tdata[0];
  assign elapsed   = (since_crossing == '1) ? since_crossing : since_crossing + 1'b1;
  assign cross_now = pin_previous && !pin &&
                     (elapsed >= {{(SINCE_W-TIME_W){1'b0}}, debounce_us});
  assign in_range  = (elapsed >= {{(SINCE_W-TIME_W){1'b0}}, min_half_len}) &&
                     (elapsed <= {{(SINCE_W-TIME_W){1'b0}}, max_half_len});
  assign avg_sum   = ({1'b0, half_cycle_avg, 3'b000} - {4'b0000, half_cycle_avg}) +
                     {{(TIME_W+4-SINCE_W){1'b0}}, elapsed};
  assign half_cycle_avg_next = (cross_now && in_range) ? avg_sum[TIME_W+2:3] : half_cycle_avg;

  always_ff @(posedge clk) begin
    if (rst) begin
      pin_previous   <= 1'b1;
      since_crossing <= '1;
      half_cycle_avg <= RST_HALF_AVG;
    end else if (in_xfer) begin
      pin_previous   <= pin;
      since_crossing <= cross_now ? '0 : elapsed;
      half_cycle_avg <= half_cycle_avg_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      p1_accepted <= cross_now;
      p1_avg      <= half_cycle_avg_next;
    end
  end

  // Latest firing point and the window the level scales.
  assign latest = $signed({{(SINCE_W-TIME_W){1'b0}}, p1_avg}) -
                  $signed({{(SINCE_W-TIME_W){1'b0}}, guard_len}) -
                  $signed({{(SINCE_W-TIME_W){1'b0}}, pulse_width});
  assign latest_clamp = latest <= $signed({{(SINCE_W-TIME_W){1'b0}}, min_fire_delay});

  always_ff @(posedge clk) begin
    if (p1_valid && ready2) begin
      p2_accepted <= p1_accepted;
      p2_avg      <= p1_avg;
      p2_use_min  <= (32'(dim_level) >= 32'(MAX_LEVEL)) || latest_clamp;
      p2_latest   <= latest[TIME_W-1:0];
      p2_window   <= latest[TIME_W-1:0] - min_fire_delay;
    end
  end

  always_ff @(posedge clk) begin
    if (p2_valid && ready3) begin
      p3_accepted <= p2_accepted;
      p3_avg      <= p2_avg;
      p3_use_min  <= p2_use_min;
      p3_latest   <= p2_latest;
      p3_product  <= {{TIME_W{1'b0}}, dim_level} * {{LVL_W{1'b0}}, p2_window};
    end
  end

  // Division by the maximum level as a multiply by its scaled reciprocal.
  assign scaled = {{RECIP_W{1'b0}}, p3_product} *
                  {{PROD_W{1'b0}}, DIV_RECIP[RECIP_W-1:0]};

  always_ff @(posedge clk) begin
    if (p3_valid && ready4) begin
      p4_accepted <= p3_accepted;
      p4_avg      <= p3_avg;
      p4_use_min  <= p3_use_min;
      p4_latest   <= p3_latest;
      p4_quotient <= scaled[DIV_SHIFT +: TIME_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
      p3_valid <= 1'b0;
      p4_valid <= 1'b0;
    end else begin
      if (ready1) p1_valid <= s_axis_tvalid;
      if (ready2) p2_valid <= p1_valid;
      if (ready3) p3_valid <= p2_valid;
      if (ready4) p4_valid <= p3_valid;
    end
  end

  // Gate sequencer.
  assign fire_delay = p4_use_min ? min_fire_delay : p4_latest - p4_quotient;

  always_comb begin
    phase_next     = PH_IDLE;
    countdown_next = '0;
    if (p4_accepted) begin
      if (dim_level != '0) begin
        phase_next     = PH_WAIT;
        countdown_next = fire_delay;
      end
    end else begin
      unique case (phase_state)
        PH_WAIT: begin
          if (countdown <= TIME_W'(1)) begin
            phase_next     = PH_PULSE;
            countdown_next = pulse_width;
          end else begin
            phase_next     = PH_WAIT;
            countdown_next = countdown - 1'b1;
          end
        end
        PH_PULSE: begin
          if (countdown > TIME_W'(1)) begin
            phase_next     = PH_PULSE;
            countdown_next = countdown - 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    fired      = !p4_accepted && (phase_state == PH_WAIT) && (phase_next == PH_PULSE);
    gate_level = phase_next == PH_PULSE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_state <= PH_IDLE;
      countdown   <= '0;
    end else if (level_off_write) begin
      phase_state <= PH_IDLE;
      countdown   <= '0;
    end else if (out_move) begin
      phase_state <= phase_next;
      countdown   <= countdown_next;
    end
  end

  always_ff @(posedge clk) begin
    if (out_move) begin
      out_gate     <= gate_level;
      out_avg      <= p4_avg;
      out_accepted <= p4_accepted;
      out_fired    <= fired;
      out_phase    <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_move) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  assign m_axis_tdata = {5'b00000, out_phase, out_fired, out_accepted, out_avg, out_gate};

`ifndef NO_ASSERTIONS
  a_fired_in_pulse: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && out_fired) |-> (out_phase == PH_PULSE))
    else $error("gate start reported outside the pulse phase");

  a_idle_count_clear: assert property (@(posedge clk) disable iff (rst)
    (phase_state == PH_IDLE) |-> (countdown == '0))
    else $error("countdown left running while idle");

  a_crossing_restarts: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && cross_now) |=> (since_crossing == '0))
    else $error("elapsed count not restarted by an accepted crossing");

  a_input_enters: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> p1_valid)
    else $error("accepted tick lost at the first stage");
`endif

endmodule
